@@ hw/rtl/ndps_pkg.sv @@
// Package for the neuron dot-product sigmoid unit.
// Holds command codes, fixed-point widths and constants, and the sigmoid table.
// No dependencies.
`default_nettype none

package ndps_pkg;

    // Command codes carried in the command field.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_FEED = 1'b1;

    // Default size of the weight store.
    localparam int MAX_INPUTS_DEF = 256;

    // Field widths.
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 40;
    localparam int BIAS_W  = 32;
    localparam int BSUM_W  = 42;
    localparam int CLAMP_W = 28;
    localparam int ACT_W   = 16;

    // Clamp limits of the biased sum, Q4.24 range [-8, 8).
    localparam logic signed [BSUM_W-1:0] SAT_HI = 42'sd134217727;
    localparam logic signed [BSUM_W-1:0] SAT_LO = -42'sd134217728;

    // Sigmoid table geometry: the table is read as four banks.
    localparam int SIG_ENTRIES = 1024;
    localparam int SIG_MID     = 512;
    localparam int SIG_IDX_W   = 10;
    localparam int BANK_CNT    = 4;
    localparam int BANK_SEL_W  = 2;
    localparam int BANK_IDX_W  = 8;

    // Depth of the result queue; also the limit on results in flight.
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = 3;
    localparam int OUT_CNT_W  = 4;

    typedef logic [SIG_ENTRIES-1:0][ACT_W-1:0] sig_table_t;

    // One result transaction.
    typedef struct packed {
        logic [ACT_W-1:0] activation;
        logic             saturated;
    } result_t;

    // Restoring long division, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // (a * b) >> 62 on Q2.62 values.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Division rounded half away from zero, truncated to an entry.
    function automatic logic [ACT_W-1:0] round_div(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [63:0] q;
        q = udiv64((num << 1) + den, den << 1);
        return q[ACT_W-1:0];
    endfunction

    // Builds the table: entry k is round(65535 / (1 + exp(-(k - 512) / 64))).
    function automatic sig_table_t build_sig_table();
        sig_table_t  t;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] q44;
        logic [63:0] den;
        logic [63:0] one_q44;
        t       = '0;
        r       = 64'h4000_0000_0000_0000;
        term    = 64'h4000_0000_0000_0000;
        q       = 64'h4000_0000_0000_0000;
        one_q44 = 64'd1 << 44;
        // exp(-1/64) in Q2.62 from the Taylor series.
        for (int n = 1; n <= 12; n++) begin
            term = udiv64(term, 64'(64 * n));
            if ((n % 2) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        // Walk outward from the midpoint; q holds exp(-j/64).
        for (int j = 0; j <= SIG_MID; j++) begin
            q44 = q >> 18;
            den = one_q44 + q44;
            if (SIG_MID + j < SIG_ENTRIES) begin
                t[SIG_MID + j] = round_div(64'd65535 << 44, den);
            end
            if (j >= 1) begin
                t[SIG_MID - j] = round_div(64'd65535 * q44, den);
            end
            q = mul_q62(q, r);
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

@@ hw/rtl/ndps_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no other dependencies.
`default_nettype none

module ndps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/neuron_dot_product_sigmoid_unit.sv @@
// Neuron dot-product sigmoid unit: weight store, multiply-accumulate, bias, sigmoid table.
// Depends on ndps_pkg and ndps_ram.
// Throughput: one transaction per cycle while s_ready is high, loads and feeds alike, no gaps between vectors.
// A result becomes valid on m_ after its last feed has passed the pipeline and been written into the result queue.
// Up to eight results may be outstanding; s_ready drops while all eight are pending.
// Reset (synchronous, aresetn low) clears the pipeline, bias and running sum; weights
// are undefined until written.
`default_nettype none

module neuron_dot_product_sigmoid_unit #(
    parameter int MAX_INPUTS = ndps_pkg::MAX_INPUTS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration: bias register.
    input  wire logic                         cfg_wr_en,
    input  wire logic [ndps_pkg::BIAS_W-1:0]  cfg_wr_data,
    // Input channel.
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic [ndps_pkg::IDX_W-1:0]   s_element_index,
    input  wire logic [ndps_pkg::VAL_W-1:0]   s_value,
    input  wire logic                         s_last,
    // Result channel.
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [ndps_pkg::ACT_W-1:0]   m_activation,
    output logic                              m_saturated
);

    localparam int AddrW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int CmpW  = ((AddrW > ndps_pkg::IDX_W) ? AddrW : ndps_pkg::IDX_W) + 1;

    // Input handshake and address decode.
    logic              s_accept;
    logic              produce;
    logic              pop;
    logic [CmpW-1:0]   idx_ext;
    logic              idx_in_range;
    logic [AddrW-1:0]  ram_addr;
    logic              ram_wr_en;
    logic [ndps_pkg::VAL_W-1:0] weight_rd;

    // Pipeline registers.
    logic                                v1_reg;
    logic                                last1_reg;
    logic                                inr1_reg;
    logic signed [ndps_pkg::VAL_W-1:0]   val1_reg;
    logic                                v2_reg;
    logic                                last2_reg;
    logic signed [ndps_pkg::PROD_W-1:0]  prod2_reg;
    logic signed [ndps_pkg::PROD_W-1:0]  prod2_next;
    logic signed [ndps_pkg::VAL_W-1:0]   weight_eff;
    logic signed [ndps_pkg::SUM_W-1:0]   sum_reg;
    logic signed [ndps_pkg::SUM_W-1:0]   sum_next;
    logic                                v3_reg;
    logic signed [ndps_pkg::SUM_W-1:0]   fin3_reg;
    logic signed [ndps_pkg::BIAS_W-1:0]  bias_reg;
    logic signed [ndps_pkg::BSUM_W-1:0]  biased;
    logic signed [ndps_pkg::CLAMP_W-1:0] clamped;
    logic                                sat_hi;
    logic                                sat_lo;
    logic                                v4_reg;
    logic [ndps_pkg::SIG_IDX_W-1:0]      k4_reg;
    logic [ndps_pkg::SIG_IDX_W-1:0]      k4_next;
    logic                                sat4_reg;
    logic                                v5_reg;
    logic [ndps_pkg::BANK_CNT-1:0][ndps_pkg::ACT_W-1:0] bank5_reg;
    logic [ndps_pkg::BANK_SEL_W-1:0]     sel5_reg;
    logic                                sat5_reg;

    // Result queue and credit counter.
    ndps_pkg::result_t                   fifo_mem [ndps_pkg::OUT_DEPTH];
    ndps_pkg::result_t                   push_data;
    ndps_pkg::result_t                   head;
    logic [ndps_pkg::OUT_PTR_W:0]        wr_ptr_reg;
    logic [ndps_pkg::OUT_PTR_W:0]        rd_ptr_reg;
    logic [ndps_pkg::OUT_CNT_W-1:0]      credit_reg;
    logic [ndps_pkg::OUT_CNT_W-1:0]      credit_next;

    // Accept while fewer than a queue's worth of results are pending.
    assign s_ready  = (credit_reg < ndps_pkg::OUT_CNT_W'(ndps_pkg::OUT_DEPTH));
    assign s_accept = s_valid && s_ready;
    assign produce  = s_accept && (s_command == ndps_pkg::CMD_FEED) && s_last;
    assign pop      = m_valid && m_ready;

    // Indexes past the store size are dropped on load and read as zero on feed.
    assign idx_ext      = CmpW'(s_element_index);
    assign idx_in_range = (idx_ext < CmpW'(MAX_INPUTS));
    assign ram_addr     = idx_ext[AddrW-1:0];
    assign ram_wr_en    = s_accept && (s_command == ndps_pkg::CMD_LOAD) && idx_in_range;

    // Weight store.
    ndps_ram #(
        .WIDTH (ndps_pkg::VAL_W),
        .DEPTH (MAX_INPUTS),
        .ADDR_W(AddrW)
    ) u_weight_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_addr),
        .wr_data(s_value),
        .rd_en  (s_accept),
        .rd_addr(ram_addr),
        .rd_data(weight_rd)
    );

    // Bias register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
        end else if (cfg_wr_en) begin
            bias_reg <= cfg_wr_data;
        end
    end

    // Stage 1: feed transaction waits for the weight read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= s_accept && (s_command == ndps_pkg::CMD_FEED);
        end
    end

    always_ff @(posedge aclk) begin
        last1_reg <= s_last;
        inr1_reg  <= idx_in_range;
        val1_reg  <= s_value;
    end

    // Stage 2: product of element and weight.
    assign weight_eff = inr1_reg ? $signed(weight_rd) : '0;
    assign prod2_next = val1_reg * weight_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        last2_reg <= last1_reg;
        prod2_reg <= prod2_next;
    end

    // Stage 3: accumulate; the last element hands the sum on and clears it.
    assign sum_next = sum_reg + ndps_pkg::SUM_W'(prod2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            v3_reg  <= 1'b0;
        end else begin
            v3_reg <= v2_reg && last2_reg;
            if (v2_reg) begin
                sum_reg <= last2_reg ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fin3_reg <= sum_next;
    end

    // Stage 4: add bias at full width, clamp to [-8, 8) and form the table index.
    assign biased  = ndps_pkg::BSUM_W'(fin3_reg) + ndps_pkg::BSUM_W'(bias_reg);
    assign sat_hi  = (biased > ndps_pkg::SAT_HI);
    assign sat_lo  = (biased < ndps_pkg::SAT_LO);
    assign clamped = sat_hi ? ndps_pkg::SAT_HI[ndps_pkg::CLAMP_W-1:0] :
                     sat_lo ? ndps_pkg::SAT_LO[ndps_pkg::CLAMP_W-1:0] :
                              biased[ndps_pkg::CLAMP_W-1:0];
    assign k4_next = {~clamped[ndps_pkg::CLAMP_W-1],
                      clamped[ndps_pkg::CLAMP_W-2:ndps_pkg::CLAMP_W-ndps_pkg::SIG_IDX_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        k4_reg   <= k4_next;
        sat4_reg <= sat_hi || sat_lo;
    end

    // Stage 5: read all four table banks at the low index bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < ndps_pkg::BANK_CNT; b++) begin
            bank5_reg[b] <= ndps_pkg::SIG_TABLE[{ndps_pkg::BANK_SEL_W'(b),
                                                 k4_reg[ndps_pkg::BANK_IDX_W-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        sel5_reg <= k4_reg[ndps_pkg::SIG_IDX_W-1:ndps_pkg::BANK_IDX_W];
        sat5_reg <= sat4_reg;
    end

    // Bank select and push into the result queue.
    assign push_data.activation = bank5_reg[sel5_reg];
    assign push_data.saturated  = sat5_reg;

    always_ff @(posedge aclk) begin
        if (v5_reg) begin
            fifo_mem[wr_ptr_reg[ndps_pkg::OUT_PTR_W-1:0]] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
        end else begin
            if (v5_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            credit_reg <= credit_next;
        end
    end

    // Credits count results accepted but not yet delivered.
    always_comb begin
        credit_next = credit_reg;
        if (produce && !pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (!produce && pop) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // Result channel driven from the queue head.
    assign head         = fifo_mem[rd_ptr_reg[ndps_pkg::OUT_PTR_W-1:0]];
    assign m_valid      = (wr_ptr_reg != rd_ptr_reg);
    assign m_activation = head.activation;
    assign m_saturated  = head.saturated;

endmodule

`default_nettype wire
